@@ hw/rtl/version_list_clamp_core_macros.svh @@
// Assertion helpers shared by the clamp core.
`ifndef VERSION_LIST_CLAMP_CORE_MACROS_SVH
`define VERSION_LIST_CLAMP_CORE_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define VLC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define VLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/vlc_pkg.sv @@
package vlc_pkg;

  localparam int unsigned VERSION_BYTES = 4;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LIMIT_W       = 32;
  localparam int unsigned VER_W         = VERSION_BYTES * BYTE_W;
  localparam int unsigned CMP_W         = (VER_W > LIMIT_W) ? VER_W : LIMIT_W;
  localparam int unsigned FILL_W        = $clog2(VERSION_BYTES + 1);

  localparam logic [BYTE_W-1:0] COLON_CHAR = 8'h3A;

  typedef logic [BYTE_W-1:0] byte_t;

  // Parser verdict for the word being accepted.
  typedef struct packed {
    logic entry_end;
    logic colon_fits;
  } vlc_parse_t;

endpackage

@@ hw/rtl/vlc_seg_if.sv @@
interface vlc_seg_if
  import vlc_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t seg_byte;
  logic  seg_last;

  modport source (output valid, output seg_byte, output seg_last, input ready);
  modport sink   (input valid, input seg_byte, input seg_last, output ready);
endinterface

@@ hw/rtl/vlc_res_if.sv @@
interface vlc_res_if
  import vlc_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_last;
  logic  seg_changed;

  modport source (output valid, output out_byte, output out_last, output seg_changed,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input seg_changed,
                  output ready);
endinterface

@@ hw/rtl/vlc_parser.sv @@
module vlc_parser
  import vlc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  byte_t      seg_byte_i,
  input  logic       seg_last_i,
  output vlc_parse_t parse_o
);

  localparam logic [BYTE_W-1:0] LeftAtVersion = BYTE_W'(VERSION_BYTES);

  logic        in_entry_q, in_entry_d;
  logic        found_q, found_d;
  logic        fits_q, fits_d;
  byte_t       left_q, left_d;
  byte_t       left_n;

  always_comb begin
    in_entry_d = in_entry_q;
    found_d    = found_q;
    fits_d     = fits_q;
    left_d     = left_q;
    left_n     = left_q - 8'd1;
    parse_o    = '0;
    if (accept_i) begin
      if (!in_entry_q) begin
        left_d     = seg_byte_i;
        found_d    = 1'b0;
        fits_d     = 1'b0;
        in_entry_d = (seg_byte_i != '0);
      end else begin
        left_d = left_n;
        // Only the first colon of an entry decides whether it qualifies.
        if (seg_byte_i == COLON_CHAR && !found_q) begin
          found_d = 1'b1;
          fits_d  = (left_n == LeftAtVersion);
        end
        if (left_n == '0) begin
          parse_o.entry_end  = 1'b1;
          parse_o.colon_fits = fits_d;
          in_entry_d = 1'b0;
          found_d    = 1'b0;
          fits_d     = 1'b0;
        end
      end
      if (seg_last_i) begin
        in_entry_d = 1'b0;
        found_d    = 1'b0;
        fits_d     = 1'b0;
        left_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_entry_q <= 1'b0;
      found_q    <= 1'b0;
      fits_q     <= 1'b0;
      left_q     <= '0;
    end else begin
      in_entry_q <= in_entry_d;
      found_q    <= found_d;
      fits_q     <= fits_d;
      left_q     <= left_d;
    end
  end

endmodule

@@ hw/rtl/vlc_hold.sv @@
`include "version_list_clamp_core_macros.svh"

module vlc_hold
  import vlc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  byte_t              seg_byte_i,
  input  logic               seg_last_i,
  input  vlc_parse_t         parse_i,
  input  logic [LIMIT_W-1:0] limit_i,
  output logic               in_ready_o,
  vlc_res_if.source          res_o
);

  localparam logic [FILL_W-1:0] FillFull = FILL_W'(VERSION_BYTES);
  localparam logic [FILL_W-1:0] FillOne  = FILL_W'(1);

  byte_t             hold_q [VERSION_BYTES];
  byte_t             hold_d [VERSION_BYTES];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              flush_q, flush_d;
  logic              chg_q, chg_d;
  logic              ov_q, ov_d;
  byte_t             ob_q, ob_d;
  logic              ol_q, ol_d;
  logic              oc_q, oc_d;
  logic              slot_free;
  logic [VER_W-1:0]  ver;
  logic [CMP_W-1:0]  lim_ext;
  logic              do_clamp;

  assign slot_free  = !ov_q || res_o.ready;
  assign in_ready_o = !flush_q && slot_free;
  assign lim_ext    = CMP_W'(limit_i);

  always_comb begin
    hold_d   = hold_q;
    fill_d   = fill_q;
    flush_d  = flush_q;
    chg_d    = chg_q;
    ov_d     = ov_q && !res_o.ready;
    ob_d     = ob_q;
    ol_d     = ol_q;
    oc_d     = oc_q;
    ver      = '0;
    do_clamp = 1'b0;
    if (accept_i) begin
      if (fill_q == FillFull) begin
        // The oldest word leaves the full delay line.
        ov_d = 1'b1;
        ob_d = hold_q[0];
        ol_d = 1'b0;
        oc_d = 1'b0;
        for (int i = 0; i < VERSION_BYTES - 1; i++) begin
          hold_d[i] = hold_q[i+1];
        end
        hold_d[VERSION_BYTES-1] = seg_byte_i;
      end else begin
        for (int i = 0; i < VERSION_BYTES; i++) begin
          if (fill_q == FILL_W'(i)) begin
            hold_d[i] = seg_byte_i;
          end
        end
        fill_d = fill_q + FillOne;
      end
      for (int i = 0; i < VERSION_BYTES; i++) begin
        ver[VER_W-1-BYTE_W*i -: BYTE_W] = hold_d[i];
      end
      // The line holds exactly the version when a qualifying entry ends.
      do_clamp = parse_i.entry_end && parse_i.colon_fits && (limit_i != '0) &&
                 (fill_d == FillFull) && (CMP_W'(ver) > lim_ext);
      if (do_clamp) begin
        for (int i = 0; i < VERSION_BYTES; i++) begin
          hold_d[i] = lim_ext[BYTE_W*(VERSION_BYTES-1-i) +: BYTE_W];
        end
        chg_d = 1'b1;
      end
      if (seg_last_i) begin
        flush_d = 1'b1;
      end
    end else if (flush_q && slot_free) begin
      ov_d = 1'b1;
      ob_d = hold_q[0];
      ol_d = (fill_q == FillOne);
      oc_d = (fill_q == FillOne) && chg_q;
      for (int i = 0; i < VERSION_BYTES - 1; i++) begin
        hold_d[i] = hold_q[i+1];
      end
      fill_d = fill_q - FillOne;
      if (fill_q == FillOne) begin
        flush_d = 1'b0;
        chg_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      flush_q <= 1'b0;
      chg_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      flush_q <= flush_d;
      chg_q   <= chg_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    ob_q   <= ob_d;
    ol_q   <= ol_d;
    oc_q   <= oc_d;
  end

  assign res_o.valid       = ov_q;
  assign res_o.out_byte    = ob_q;
  assign res_o.out_last    = ol_q;
  assign res_o.seg_changed = oc_q;

  `VLC_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FillFull, "delay line overfilled")
  `VLC_ASSERT(a_flush_nonempty, clk_i, rst_ni, flush_q |-> fill_q != '0, "flush with empty line")
  `VLC_ASSERT(a_last_flushes, clk_i, rst_ni, (accept_i && seg_last_i) |=> flush_q, "no flush after last word")
  `VLC_ASSERT(a_chg_on_last, clk_i, rst_ni, (ov_q && !ol_q) |-> !oc_q, "change flag off the last word")

endmodule

@@ hw/rtl/version_list_clamp_core.sv @@
// Latency: a word leaves once VERSION_BYTES later words have arrived, or at segment end.
// Throughput: one word per cycle while a segment streams in and the output is ready.
// At segment end the held words (up to VERSION_BYTES) drain one per cycle while the output
// is ready, during which no input is accepted.
// Reset (rst_ni, asynchronous, active low) clears the parser, the delay line fill,
// the output valid flag and sets the version limit to zero (pass-through).
module version_list_clamp_core
  import vlc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  vlc_seg_if.sink            seg_i,
  vlc_res_if.source          res_o,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i
);

  logic [LIMIT_W-1:0] limit_q;
  logic               in_ready;
  logic               accept;
  vlc_parse_t         parse;

  assign seg_i.ready = in_ready;
  assign accept      = seg_i.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  vlc_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .seg_byte_i (seg_i.seg_byte),
    .seg_last_i (seg_i.seg_last),
    .parse_o    (parse)
  );

  vlc_hold u_hold (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .seg_byte_i (seg_i.seg_byte),
    .seg_last_i (seg_i.seg_last),
    .parse_i    (parse),
    .limit_i    (limit_q),
    .in_ready_o (in_ready),
    .res_o      (res_o)
  );

endmodule
